>>> sv/eeprom_control_sequencer_assert.svh
// assertion macros, clocked on clk, disabled while arst_n is low
`ifndef EEPROM_CONTROL_SEQUENCER_ASSERT_SVH
`define EEPROM_CONTROL_SEQUENCER_ASSERT_SVH

`define ECS_ASSERT_HOLD(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("ecs check failed");

`define ECS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ecs check failed");

`define ECS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ecs check failed");

`endif

>>> sv/ecs_pkg.sv
package ecs_pkg;

	// depth must be a power of two; the byte address wraps on it
	localparam int STORE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int VALUE_W     = 10;
	localparam int TICK_W      = 20;
	localparam int PADDR_W     = 4;

	localparam logic [7:0]        ERASED_BYTE  = 8'hFF;
	localparam logic [TICK_W-1:0] WINDOW_TICKS = 20'd4;

	localparam logic [2:0] STALL_NONE  = 3'd0;
	localparam logic [2:0] STALL_WRITE = 3'd2;
	localparam logic [2:0] STALL_READ  = 3'd4;

	localparam logic [TICK_W-1:0] RST_ATOMIC_TICKS = 20'd54400;
	localparam logic [TICK_W-1:0] RST_SPLIT_TICKS  = 20'd28800;
	localparam logic [TICK_W-1:0] RST_LEGACY_TICKS = 20'd136000;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_CTRL,
		OP_ADDR,
		OP_DATA
	} opcode_t;

	typedef enum logic [1:0] {
		REG_HAS_MODE,
		REG_ATOMIC,
		REG_SPLIT,
		REG_LEGACY
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_ATOMIC,
		MODE_ERASE,
		MODE_WRITE,
		MODE_RSVD
	} mode_t;

	typedef struct packed {
		logic              has_mode;
		logic [TICK_W-1:0] atomic_ticks;
		logic [TICK_W-1:0] split_ticks;
		logic [TICK_W-1:0] legacy_ticks;
	} cfg_t;

	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wr_data;
	} mem_req_t;

	function automatic logic [ADDR_W-1:0] store_index(logic [VALUE_W-1:0] a);
		return ADDR_W'(a);
	endfunction

endpackage

>>> sv/ecs_chan_if.sv
interface ecs_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [9:0] value;

	modport source(output valid, output opcode, output value, input ready);
	modport sink(input valid, input opcode, input value, output ready);
endinterface

interface ecs_result_if;
	logic       valid;
	logic       ready;
	logic [5:0] control_bits;
	logic [7:0] data_value;
	logic [2:0] stall_cycles;

	modport source(output valid, output control_bits, output data_value,
		output stall_cycles, input ready);
	modport sink(input valid, input control_bits, input data_value,
		input stall_cycles, output ready);
endinterface

>>> sv/ecs_cfg.sv
module ecs_cfg
	import ecs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.has_mode     <= 1'b1;
			cfg_q.atomic_ticks <= RST_ATOMIC_TICKS;
			cfg_q.split_ticks  <= RST_SPLIT_TICKS;
			cfg_q.legacy_ticks <= RST_LEGACY_TICKS;
		end else if (wr) begin
			unique case (idx)
				REG_HAS_MODE: cfg_q.has_mode     <= pwdata[0];
				REG_ATOMIC:   cfg_q.atomic_ticks <= pwdata[TICK_W-1:0];
				REG_SPLIT:    cfg_q.split_ticks  <= pwdata[TICK_W-1:0];
				REG_LEGACY:   cfg_q.legacy_ticks <= pwdata[TICK_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_HAS_MODE: prdata = 32'(cfg_q.has_mode);
			REG_ATOMIC:   prdata = 32'(cfg_q.atomic_ticks);
			REG_SPLIT:    prdata = 32'(cfg_q.split_ticks);
			REG_LEGACY:   prdata = 32'(cfg_q.legacy_ticks);
		endcase
	end

endmodule

>>> sv/ecs_store.sv
module ecs_store
	import ecs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  mem_req_t   req,
	output logic [7:0] rd_data,
	output logic       clearing
);

	logic [7:0]        mem [STORE_DEPTH];
	logic [7:0]        rd_data_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              clearing_q;

	assign rd_data  = rd_data_q;
	assign clearing = clearing_q;

	// erase sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(STORE_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= ERASED_BYTE;
		end else if (req.wr_en) begin
			mem[req.addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.addr];
		end
	end

endmodule

>>> sv/ecs_ctrl.sv
`include "eeprom_control_sequencer_assert.svh"

module ecs_ctrl
	import ecs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	ecs_item_if.sink   item,
	ecs_result_if.source result,
	input  cfg_t       cfg,
	input  logic       clearing,
	input  logic [7:0] rd_data,
	output mem_req_t   mem_req
);

	logic [5:0]         ctrl_q, ctrl_d;
	mode_t              mode_q, mode_d;
	logic               prior_me_q, prior_me_d;
	logic               prior_pe_q, prior_pe_d;
	logic [TICK_W-1:0]  timer_q, timer_d;
	logic               pending_q, pending_d;
	logic [VALUE_W-1:0] addr_q, addr_d;
	logic [7:0]         data_q, data_d;

	logic               rd_s1;
	logic               out_valid_q;
	logic [5:0]         out_ctrl_q;
	logic [7:0]         out_data_q;
	logic [2:0]         out_stall_q;

	logic               accept;
	logic [2:0]         stall_d;
	logic               rd_req, wr_req;
	logic [5:0]         cr;
	logic               me, pe;
	logic [7:0]         wr_byte;
	logic [TICK_W-1:0]  raw_ticks, wr_ticks, timer_dec;

	assign item.ready = !clearing && !rd_s1 && (!out_valid_q || result.ready);
	assign accept     = item.valid && item.ready;

	assign result.valid        = out_valid_q;
	assign result.control_bits = out_ctrl_q;
	assign result.data_value   = out_data_q;
	assign result.stall_cycles = out_stall_q;

	assign mem_req.rd_en   = rd_req;
	assign mem_req.wr_en   = wr_req;
	assign mem_req.addr    = store_index(addr_q);
	assign mem_req.wr_data = wr_byte;

	// program byte and busy time for a write start, and the decremented timer
	always_comb begin
		wr_byte   = data_q;
		raw_ticks = cfg.legacy_ticks;
		if (cfg.has_mode) begin
			if (mode_q == MODE_ATOMIC) begin
				raw_ticks = cfg.atomic_ticks;
			end else begin
				raw_ticks = cfg.split_ticks;
				if (mode_q == MODE_ERASE) begin
					wr_byte = ERASED_BYTE;
				end
			end
		end
		wr_ticks  = (raw_ticks == '0) ? TICK_W'(1) : raw_ticks;
		timer_dec = timer_q - TICK_W'(timer_q != '0);
	end

	always_comb begin
		ctrl_d     = ctrl_q;
		mode_d     = mode_q;
		prior_me_d = prior_me_q;
		prior_pe_d = prior_pe_q;
		timer_d    = timer_q;
		pending_d  = pending_q;
		addr_d     = addr_q;
		data_d     = data_q;
		stall_d    = STALL_NONE;
		rd_req     = 1'b0;
		wr_req     = 1'b0;
		cr         = item.value[5:0];
		if (!cfg.has_mode) begin
			cr[5:4] = 2'b00;
		end
		me = cr[2];
		pe = cr[1];
		if (accept) begin
			unique case (opcode_t'(item.opcode))
				OP_TICK: begin
					if (pending_q) begin
						timer_d = timer_dec;
						if (timer_dec == '0) begin
							pending_d = 1'b0;
							if (ctrl_q[2]) begin
								ctrl_d[2] = 1'b0;
							end else begin
								ctrl_d[1] = 1'b0;
							end
						end
					end
				end
				OP_CTRL: begin
					if (!pe) begin
						mode_d = mode_t'(cr[5:4]);
						if (cr[0]) begin
							cr[0]   = 1'b0;
							stall_d = STALL_READ;
							rd_req  = 1'b1;
						end
					end
					if (me && !prior_pe_q && pe) begin
						cr[2]     = 1'b0;
						wr_req    = 1'b1;
						timer_d   = wr_ticks;
						pending_d = 1'b1;
						stall_d   = STALL_WRITE;
					end else begin
						if (me && !prior_me_q) begin
							timer_d   = WINDOW_TICKS;
							pending_d = 1'b1;
						end
						prior_me_d = me;
						prior_pe_d = pe;
					end
					ctrl_d = cr;
				end
				OP_ADDR: addr_d = item.value;
				OP_DATA: data_d = item.value[7:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q      <= '0;
			mode_q      <= MODE_ATOMIC;
			prior_me_q  <= 1'b0;
			prior_pe_q  <= 1'b0;
			timer_q     <= '0;
			pending_q   <= 1'b0;
			addr_q      <= '0;
			data_q      <= '0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (accept) begin
			ctrl_q      <= ctrl_d;
			mode_q      <= mode_d;
			prior_me_q  <= prior_me_d;
			prior_pe_q  <= prior_pe_d;
			timer_q     <= timer_d;
			pending_q   <= pending_d;
			addr_q      <= addr_d;
			data_q      <= data_d;
			rd_s1       <= rd_req;
			out_valid_q <= !rd_req;
		end else if (rd_s1) begin
			data_q      <= rd_data;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_ctrl_q  <= ctrl_d;
			out_stall_q <= stall_d;
			out_data_q  <= data_d;
		end else if (rd_s1) begin
			out_data_q <= rd_data;
		end
	end

	`ECS_ASSERT_IMPL(a_timer_live, pending_q, timer_q != '0)
	`ECS_ASSERT_HOLD(a_one_port, !(mem_req.rd_en && mem_req.wr_en))
	`ECS_ASSERT_NEXT(a_read_issue, mem_req.rd_en, rd_s1 && !result.valid)
	`ECS_ASSERT_NEXT(a_read_done, rd_s1, result.valid)
	`ECS_ASSERT_IMPL(a_busy_block, rd_s1 || clearing, !item.ready)

endmodule

>>> sv/eeprom_control_sequencer.sv
// Latency: a word's result is registered and valid the cycle after accept;
// a control write that reads the store returns it via the store read
// register and rd_s1. Throughput: one word per cycle while the result is
// taken; a store read holds the input while rd_s1 is set on the single port.
// Reset: control and config registers reset at once, then the store erases
// all STORE_DEPTH (1024) bytes, taking no word; APB writes are accepted.
module eeprom_control_sequencer
	import ecs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	ecs_item_if.sink           item,
	ecs_result_if.source       result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	cfg_t       cfg;
	mem_req_t   mem_req;
	logic [7:0] rd_data;
	logic       clearing;

	ecs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ecs_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (mem_req),
		.rd_data  (rd_data),
		.clearing (clearing)
	);

	ecs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.result   (result),
		.cfg      (cfg),
		.clearing (clearing),
		.rd_data  (rd_data),
		.mem_req  (mem_req)
	);

endmodule
